### rtl/cwmd_pkg.sv
// Shared types and constants of the circular window median depth unit.
package cwmd_pkg;

    localparam int DEPTH_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERCENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd5;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
    localparam logic [1:0] STATUS_FEW = 2'd2;

    localparam logic [6:0] PCT_MIN = 7'd5;
    localparam logic [6:0] PCT_MAX = 7'd100;
    localparam int PROD_W = 21;
    localparam logic [PROD_W-1:0] RADIUS_ROUND = 21'd800;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W = PROD_W + 22;
    localparam logic [RECIP_W-1:0] RECIP_1600 = 43'd2684355;
    localparam logic [10:0] RADIUS_MIN = 11'd2;

    typedef struct packed {
        logic [13:0] center_x;
        logic [13:0] center_y;
        logic [13:0] object_radius;
        logic [9:0]  pixel_col;
        logic [9:0]  pixel_row;
        logic [15:0] depth_value;
        logic        last_pixel;
    } pix_in_t;

    typedef struct packed {
        logic [15:0] median_depth_mm;
        logic [1:0]  status;
        logic [8:0]  kept_count;
        logic        overflow;
    } res_out_t;

    typedef struct packed {
        logic [6:0]  sample_percent;
        logic [8:0]  min_valid_samples;
        logic [12:0] near_limit_cm;
        logic [12:0] far_limit_cm;
        logic [10:0] image_width;
        logic [10:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic keep;
        logic last;
        logic centre_outside;
        logic [DEPTH_W-1:0] depth;
    } pix_res_t;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } cell_cmd_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] val;
        logic gt;
        logic occ;
    } cell_link_t;

endpackage

### rtl/cwmd_cell.sv
// One cell of the sorting chain: holds one kept depth in ascending order.
module cwmd_cell
    import cwmd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_cmd_t          cmd,
    input  logic [DEPTH_W-1:0] new_val,
    input  cell_link_t         left,
    input  logic [DEPTH_W-1:0] right_val,
    output cell_link_t         link
);

    logic [DEPTH_W-1:0] val_reg, val_next;
    logic occ_reg, occ_next;
    logic gt;

    assign gt = !occ_reg || (val_reg > new_val);

    always_comb begin
        val_next = val_reg;
        occ_next = occ_reg;
        if (cmd.clear) begin
            occ_next = 1'b0;
        end else if (cmd.shift) begin
            val_next = right_val;
        end else if (cmd.insert) begin
            occ_next = occ_reg | left.occ;
            if (gt) begin
                val_next = left.gt ? left.val : new_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign link.val = val_reg;
    assign link.gt  = gt;
    assign link.occ = occ_reg;

endmodule

### rtl/cwmd_front.sv
// Pixel pipeline: rounds the centre, scales the radius and decides whether a pixel is kept.
module cwmd_front
    import cwmd_pkg::*;
#(
    parameter int MAX_IMAGE_DIM = 1024
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     accept,
    input  pix_in_t  pix,
    input  cfg_t     cfg,
    output pix_res_t res,
    output logic     last_in_flight
);

    logic [6:0]  pct;
    logic [10:0] w, h;
    logic [14:0] cx_sum, cy_sum;
    logic [10:0] cx, cy;
    logic [16:0] lo_wide;
    logic [15:0] lo_mm;
    logic [13:0] near_p1, far_cm;
    logic [17:0] hi_wide;
    logic [15:0] hi_mm;

    logic v1_reg, last1_reg, inimg1_reg, band1_reg, out1_reg;
    logic [15:0] depth1_reg;
    logic [PROD_W-1:0] p1_reg;
    logic signed [11:0] dx1_reg, dy1_reg;

    logic v2_reg, last2_reg, inimg2_reg, band2_reg, out2_reg;
    logic [15:0] depth2_reg;
    logic [10:0] rraw2_reg;
    logic [21:0] dxsq2_reg, dysq2_reg;
    logic [RECIP_W-1:0] rprod;
    logic signed [23:0] dxsq, dysq;

    logic v3_reg, last3_reg, inimg3_reg, band3_reg, out3_reg;
    logic [15:0] depth3_reg;
    logic [21:0] r2_3_reg;
    logic [22:0] d2_3_reg;
    logic [10:0] r_clamped;

    always_comb begin
        pct = cfg.sample_percent;
        if (pct < PCT_MIN) begin
            pct = PCT_MIN;
        end else if (pct > PCT_MAX) begin
            pct = PCT_MAX;
        end
        w = ({21'd0, cfg.image_width} > MAX_IMAGE_DIM) ? 11'(MAX_IMAGE_DIM) : cfg.image_width;
        h = ({21'd0, cfg.image_height} > MAX_IMAGE_DIM) ? 11'(MAX_IMAGE_DIM) : cfg.image_height;
        cx_sum = {1'b0, pix.center_x} + 15'd8;
        cy_sum = {1'b0, pix.center_y} + 15'd8;
        cx = cx_sum[14:4];
        cy = cy_sum[14:4];
        lo_wide = 17'({cfg.near_limit_cm, 3'b000}) + 17'({cfg.near_limit_cm, 1'b0});
        lo_mm = lo_wide[16] ? 16'hFFFF : lo_wide[15:0];
        near_p1 = {1'b0, cfg.near_limit_cm} + 14'd1;
        far_cm = ({1'b0, cfg.far_limit_cm} < near_p1) ? near_p1 : {1'b0, cfg.far_limit_cm};
        hi_wide = 18'({far_cm, 3'b000}) + 18'({far_cm, 1'b0});
        hi_mm = (hi_wide[17:16] != 2'b00) ? 16'hFFFF : hi_wide[15:0];
    end

    assign rprod = RECIP_W'(p1_reg) * RECIP_1600;
    assign dxsq = dx1_reg * dx1_reg;
    assign dysq = dy1_reg * dy1_reg;
    assign r_clamped = (rraw2_reg < RADIUS_MIN) ? RADIUS_MIN : rraw2_reg;

    always_ff @(posedge aclk) begin
        depth1_reg <= pix.depth_value;
        last1_reg  <= pix.last_pixel;
        inimg1_reg <= ({1'b0, pix.pixel_col} < w) && ({1'b0, pix.pixel_row} < h);
        band1_reg  <= (pix.depth_value >= lo_mm) && (pix.depth_value <= hi_mm);
        out1_reg   <= (cx >= w) || (cy >= h);
        p1_reg     <= PROD_W'(pix.object_radius) * PROD_W'(pct) + RADIUS_ROUND;
        dx1_reg    <= $signed({2'b00, pix.pixel_col}) - $signed({1'b0, cx});
        dy1_reg    <= $signed({2'b00, pix.pixel_row}) - $signed({1'b0, cy});

        depth2_reg <= depth1_reg;
        last2_reg  <= last1_reg;
        inimg2_reg <= inimg1_reg;
        band2_reg  <= band1_reg;
        out2_reg   <= out1_reg;
        rraw2_reg  <= rprod[RECIP_SHIFT+10:RECIP_SHIFT];
        dxsq2_reg  <= dxsq[21:0];
        dysq2_reg  <= dysq[21:0];

        depth3_reg <= depth2_reg;
        last3_reg  <= last2_reg;
        inimg3_reg <= inimg2_reg;
        band3_reg  <= band2_reg;
        out3_reg   <= out2_reg;
        r2_3_reg   <= 22'(r_clamped) * 22'(r_clamped);
        d2_3_reg   <= 23'(dxsq2_reg) + 23'(dysq2_reg);

        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign res.valid = v3_reg;
    assign res.keep = inimg3_reg && band3_reg && (d2_3_reg <= {1'b0, r2_3_reg});
    assign res.last = last3_reg;
    assign res.centre_outside = out3_reg;
    assign res.depth = depth3_reg;

    assign last_in_flight = (v1_reg && last1_reg) || (v2_reg && last2_reg) ||
                            (v3_reg && last3_reg);

endmodule

### rtl/circular_window_median_depth_unit.sv
// Top level: configuration registers, sorting chain of cells and result sequencing.
// A run takes one pixel per cycle; the kept depths are held sorted in the chain of cells.
// After the last pixel is accepted, it passes the three pipeline stages and a status step;
// when ok, the chain then shifts kept_count/2 times before the result is registered.
// Input is held off from the last pixel until its result is registered, once m_ is free.
// Reset (aresetn, synchronous, active low) restores the register defaults and empties the run.
module circular_window_median_depth_unit
    import cwmd_pkg::*;
#(
    parameter int MAX_SAMPLES   = 256,
    parameter int MAX_IMAGE_DIM = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pix_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output res_out_t              m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    cfg_t cfg_reg;
    logic [CNT_W-1:0] count_reg, count_next, count_new;
    logic [CNT_W-1:0] shift_reg, shift_next;
    logic ovf_reg, ovf_next, ovf_new;
    logic [1:0] status_reg, status_next;
    logic m_valid_reg, m_valid_next;
    res_out_t m_data_reg, m_data_next;

    logic accept;
    logic last_in_flight;
    logic full;
    logic few;
    pix_res_t pres;
    cell_cmd_t cmd;
    cell_link_t link [MAX_SAMPLES+1];

    assign cfg_ready = 1'b1;
    assign s_ready = (state_reg == ST_RUN) && !last_in_flight;
    assign accept = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_percent    <= 7'd80;
            cfg_reg.min_valid_samples <= 9'd10;
            cfg_reg.near_limit_cm     <= 13'd50;
            cfg_reg.far_limit_cm      <= 13'd450;
            cfg_reg.image_width       <= 11'd640;
            cfg_reg.image_height      <= 11'd480;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SAMPLE_PERCENT: cfg_reg.sample_percent <= cfg_data[6:0];
                CFG_MIN_VALID:      cfg_reg.min_valid_samples <= cfg_data[8:0];
                CFG_NEAR_LIMIT:     cfg_reg.near_limit_cm <= cfg_data;
                CFG_FAR_LIMIT:      cfg_reg.far_limit_cm <= cfg_data;
                CFG_IMAGE_WIDTH:    cfg_reg.image_width <= cfg_data[10:0];
                CFG_IMAGE_HEIGHT:   cfg_reg.image_height <= cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    cwmd_front #(
        .MAX_IMAGE_DIM(MAX_IMAGE_DIM)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .pix           (s_data),
        .cfg           (cfg_reg),
        .res           (pres),
        .last_in_flight(last_in_flight)
    );

    assign full = (count_reg == CNT_W'(MAX_SAMPLES));
    assign count_new = count_reg + CNT_W'(cmd.insert);
    assign ovf_new = ovf_reg || (pres.valid && pres.keep && full);
    assign few = (count_new == '0) ||
                 (CMP_W'(count_new) < CMP_W'(cfg_reg.min_valid_samples));

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        shift_next   = shift_reg;
        ovf_next     = ovf_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_RUN: begin
                cmd.insert = pres.valid && pres.keep && !full;
                if (pres.valid) begin
                    count_next = count_new;
                    ovf_next   = ovf_new;
                    if (pres.last) begin
                        shift_next = count_new >> 1;
                        if (pres.centre_outside) begin
                            status_next = STATUS_OUTSIDE;
                            state_next  = ST_EMIT;
                        end else if (few) begin
                            status_next = STATUS_FEW;
                            state_next  = ST_EMIT;
                        end else begin
                            status_next = STATUS_OK;
                            state_next  = ST_SHIFT;
                        end
                    end
                end
            end
            ST_SHIFT: begin
                if (shift_reg == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.shift  = 1'b1;
                    shift_next = shift_reg - CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.median_depth_mm = (status_reg == STATUS_OK) ? link[1].val : '0;
                    m_data_next.status     = status_reg;
                    m_data_next.kept_count = 9'(count_reg);
                    m_data_next.overflow   = ovf_reg;
                    cmd.clear  = 1'b1;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        shift_reg  <= shift_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign link[0].val = pres.depth;
    assign link[0].gt  = 1'b0;
    assign link[0].occ = 1'b1;

    for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
        logic [DEPTH_W-1:0] right_val;
        if (i == MAX_SAMPLES - 1) begin : g_end
            assign right_val = link[i+1].val;
        end else begin : g_mid
            assign right_val = link[i+2].val;
        end
        cwmd_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .new_val  (pres.depth),
            .left     (link[i]),
            .right_val(right_val),
            .link     (link[i+1])
        );
    end

endmodule

### dv/cwmd_median_checker.sv
// Checker for the median depth unit: predicts each result from the observed requests and compares.
module cwmd_median_checker
    import cwmd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  pix_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  res_out_t              m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    pending_results,
    output int                    ok_results,
    output int                    outside_results,
    output int                    few_results,
    output int                    overflow_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 256;
    localparam int DIM_LIMIT = 1024;

    cfg_t        regs;
    logic [15:0] kept_depths[$];
    logic        run_overflow;
    res_out_t    predicted_results[$];

    function automatic int cm_to_mm(input int cm);
        return (cm * 10 > 65535) ? 65535 : cm * 10;
    endfunction

    task automatic predict_depth_pixel(input pix_in_t p);
        int          w;
        int          h;
        int          cx;
        int          cy;
        int          pct;
        int          r;
        int          dx;
        int          dy;
        int          near_cm;
        int          far_cm;
        int          lo_mm;
        int          hi_mm;
        int          n;
        logic        keep;
        res_out_t    res;
        logic [15:0] ordered[$];
        w = (int'(regs.image_width) > DIM_LIMIT) ? DIM_LIMIT : int'(regs.image_width);
        h = (int'(regs.image_height) > DIM_LIMIT) ? DIM_LIMIT : int'(regs.image_height);
        cx = (int'(p.center_x) + 8) >> 4;
        cy = (int'(p.center_y) + 8) >> 4;
        pct = int'(regs.sample_percent);
        if (pct < int'(PCT_MIN)) begin
            pct = int'(PCT_MIN);
        end
        if (pct > int'(PCT_MAX)) begin
            pct = int'(PCT_MAX);
        end
        r = (int'(p.object_radius) * pct + 800) / 1600;
        if (r < 2) begin
            r = 2;
        end
        near_cm = int'(regs.near_limit_cm);
        far_cm = int'(regs.far_limit_cm);
        if (far_cm < near_cm + 1) begin
            far_cm = near_cm + 1;
        end
        lo_mm = cm_to_mm(near_cm);
        hi_mm = cm_to_mm(far_cm);
        dx = int'(p.pixel_col) - cx;
        dy = int'(p.pixel_row) - cy;
        keep = (int'(p.pixel_col) < w) && (int'(p.pixel_row) < h) &&
               (dx * dx + dy * dy <= r * r) &&
               (int'(p.depth_value) >= lo_mm) && (int'(p.depth_value) <= hi_mm);
        if (keep) begin
            if (kept_depths.size() < STORE_DEPTH) begin
                kept_depths = {kept_depths, p.depth_value};
            end else begin
                run_overflow = 1'b1;
            end
        end
        if (p.last_pixel) begin
            n = kept_depths.size();
            res.median_depth_mm = '0;
            res.kept_count = 9'(n);
            res.overflow = run_overflow;
            if (cx >= w || cy >= h) begin
                res.status = STATUS_OUTSIDE;
            end else if (n == 0 || n < int'(regs.min_valid_samples)) begin
                res.status = STATUS_FEW;
            end else begin
                res.status = STATUS_OK;
                ordered = kept_depths;
                ordered.sort();
                res.median_depth_mm = ordered[n / 2];
            end
            predicted_results = {predicted_results, res};
            kept_depths.delete();
            run_overflow = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        res_out_t want;
        if (!aresetn) begin
            regs = '{sample_percent: 7'd80, min_valid_samples: 9'd10,
                     near_limit_cm: 13'd50, far_limit_cm: 13'd450,
                     image_width: 11'd640, image_height: 11'd480};
            kept_depths.delete();
            predicted_results.delete();
            run_overflow = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SAMPLE_PERCENT: regs.sample_percent = cfg_data[6:0];
                    CFG_MIN_VALID: regs.min_valid_samples = cfg_data[8:0];
                    CFG_NEAR_LIMIT: regs.near_limit_cm = cfg_data[12:0];
                    CFG_FAR_LIMIT: regs.far_limit_cm = cfg_data[12:0];
                    CFG_IMAGE_WIDTH: regs.image_width = cfg_data[10:0];
                    CFG_IMAGE_HEIGHT: regs.image_height = cfg_data[10:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_depth_pixel(s_data);
            end
            if (m_valid && m_ready) begin
                case (m_data.status)
                    STATUS_OK: ok_results++;
                    STATUS_OUTSIDE: outside_results++;
                    default: few_results++;
                endcase
                if (m_data.overflow) begin
                    overflow_results++;
                end
                if (predicted_results.size() == 0) begin
                    $display("%0t: result with no request outstanding, expected none, actual %p",
                             $time, m_data);
                    mismatch_count++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("median_depth_mm", int'(want.median_depth_mm),
                                int'(m_data.median_depth_mm));
                    check_field("status", int'(want.status), int'(m_data.status));
                    check_field("kept_count", int'(want.kept_count), int'(m_data.kept_count));
                    check_field("overflow", int'(want.overflow), int'(m_data.overflow));
                end
            end
        end
        pending_results = predicted_results.size();
    end

endmodule

### dv/tb_circular_window_median_depth_unit.sv
// Testbench top for the median depth unit: reset, register settings, pixel stimulus and verdict.
module tb_circular_window_median_depth_unit;
    import cwmd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 160;
    localparam int RANDOM_PIXELS = 1300;
    localparam int NUM_SETTINGS = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    pix_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    res_out_t              m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int   mismatch_count;
    int   pending_results;
    int   ok_results;
    int   outside_results;
    int   few_results;
    int   overflow_results;
    int   send_idle_pct = 36;
    int   recv_idle_pct = 74;
    int   pixels_sent = 0;
    cfg_t active_cfg = '{sample_percent: 7'd80, min_valid_samples: 9'd10,
                         near_limit_cm: 13'd50, far_limit_cm: 13'd450,
                         image_width: 11'd640, image_height: 11'd480};

    always #5ns aclk = ~aclk;

    circular_window_median_depth_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cwmd_median_checker median_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .pending_results  (pending_results),
        .ok_results       (ok_results),
        .outside_results  (outside_results),
        .few_results      (few_results),
        .overflow_results (overflow_results)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic pix_in_t pix(input int cx16, input int cy16, input int rad16,
                                    input int col, input int row, input int depth,
                                    input bit last);
        pix_in_t p;
        p.center_x = 14'(cx16);
        p.center_y = 14'(cy16);
        p.object_radius = 14'(rad16);
        p.pixel_col = 10'(col);
        p.pixel_row = 10'(row);
        p.depth_value = 16'(depth);
        p.last_pixel = last;
        return p;
    endfunction

    task automatic send_pixel(input pix_in_t p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= p;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
    endtask

    // The block may still be working on a run after its last result has left.
    task automatic wait_results(input int settle_cycles);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) begin
            @(posedge aclk);
        end
        repeat (settle_cycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_setting(input int sel);
        cfg_t c;
        case (sel)
            0: c = '{7'd0, 9'd0, 13'd0, 13'd0, 11'd1024, 11'd1024};
            1: c = '{7'd127, 9'd256, 13'd8191, 13'd8191, 11'd2047, 11'd2047};
            2: c = '{7'd100, 9'd1, 13'd30, 13'd6553, 11'd640, 11'd480};
            3: c = '{7'($urandom_range(0, 127)), 9'($urandom_range(0, 24)),
                     13'($urandom_range(0, 800)), 13'($urandom_range(0, 8191)),
                     11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024))};
            4: c = '{7'd5, 9'd511, 13'd6000, 13'd6553, 11'd1, 11'd1};
            5: c = '{7'd50, 9'd5, 13'd200, 13'd100, 11'd1023, 11'd700};
            default: c = '{7'd80, 9'd10, 13'd50, 13'd450, 11'd0, 11'd0};
        endcase
        write_reg(CFG_SAMPLE_PERCENT, int'(c.sample_percent));
        write_reg(CFG_MIN_VALID, int'(c.min_valid_samples));
        write_reg(CFG_NEAR_LIMIT, int'(c.near_limit_cm));
        write_reg(CFG_FAR_LIMIT, int'(c.far_limit_cm));
        write_reg(CFG_IMAGE_WIDTH, int'(c.image_width));
        write_reg(CFG_IMAGE_HEIGHT, int'(c.image_height));
        write_reg(CFG_SPARE_LO, $urandom_range(0, 8191));
        write_reg(CFG_SPARE_HI, $urandom_range(0, 8191));
        cfg_valid <= 1'b0;
        active_cfg = c;
    endtask

    // Well-formed runs circle one centre with depths mostly in the band; noisy runs are random.
    task automatic send_run(input int len, input bit noisy, input bit dense);
        pix_in_t p;
        int      w;
        int      h;
        int      near_cm;
        int      far_cm;
        int      lo_mm;
        int      hi_mm;
        int      bx;
        int      by;
        int      brad;
        int      cx;
        int      cy;
        int      reach;
        int      col;
        int      row;
        int      depth;
        w = (int'(active_cfg.image_width) > 1024) ? 1024 : int'(active_cfg.image_width);
        h = (int'(active_cfg.image_height) > 1024) ? 1024 : int'(active_cfg.image_height);
        near_cm = int'(active_cfg.near_limit_cm);
        far_cm = int'(active_cfg.far_limit_cm);
        if (far_cm < near_cm + 1) begin
            far_cm = near_cm + 1;
        end
        lo_mm = (near_cm * 10 > 65535) ? 65535 : near_cm * 10;
        hi_mm = (far_cm * 10 > 65535) ? 65535 : far_cm * 10;
        bx = (w == 0) ? $urandom_range(0, 16383) : $urandom_range(0, w * 16 - 1);
        by = (h == 0) ? $urandom_range(0, 16383) : $urandom_range(0, h * 16 - 1);
        brad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 640);
        cx = (bx + 8) >> 4;
        cy = (by + 8) >> 4;
        reach = dense ? 1 : ((brad >> 4) + 2 > 200 ? 200 : (brad >> 4) + 2);
        for (int i = 0; i < len; i++) begin
            if (noisy) begin
                p = pix($urandom_range(0, 16383), $urandom_range(0, 16383),
                        $urandom_range(0, 16383), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 65535), 1'b0);
            end else begin
                col = cx + $urandom_range(0, 2 * reach) - reach;
                row = cy + $urandom_range(0, 2 * reach) - reach;
                col = (col < 0) ? 0 : ((col > 1023) ? 1023 : col);
                row = (row < 0) ? 0 : ((row > 1023) ? 1023 : row);
                depth = ($urandom_range(0, 99) < 85) ? $urandom_range(lo_mm, hi_mm)
                                                     : $urandom_range(0, 65535);
                p = pix(bx, by, brad, col, row, depth, 1'b0);
                if ($urandom_range(0, 19) == 0) begin
                    p.center_x = 14'($urandom_range(0, 16383));
                    p.center_y = 14'($urandom_range(0, 16383));
                    p.object_radius = 14'($urandom_range(0, 16383));
                end
            end
            p.last_pixel = (i == len - 1);
            send_pixel(p);
        end
    endtask

    initial begin
        int  sent_in_phase;
        int  len;
        bit  dense;
        bit  paused;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Band edges and circle edge around one centre, ten samples giving an ok result.
        send_pixel(pix(1600, 1600, 160, 100, 100, 500, 1'b0));
        send_pixel(pix(1600, 1600, 160, 108, 100, 4500, 1'b0));
        send_pixel(pix(1600, 1600, 160, 100, 92, 1234, 1'b0));
        send_pixel(pix(1600, 1600, 160, 109, 100, 2000, 1'b0));
        send_pixel(pix(1600, 1600, 160, 106, 106, 800, 1'b0));
        send_pixel(pix(1600, 1600, 160, 105, 106, 900, 1'b0));
        send_pixel(pix(1600, 1600, 160, 100, 100, 499, 1'b0));
        send_pixel(pix(1600, 1600, 160, 100, 100, 4501, 1'b0));
        send_pixel(pix(1600, 1600, 160, 101, 100, 3000, 1'b0));
        send_pixel(pix(1600, 1600, 160, 99, 101, 2500, 1'b0));
        send_pixel(pix(1600, 1600, 160, 102, 102, 1500, 1'b0));
        send_pixel(pix(1600, 1600, 160, 97, 98, 700, 1'b0));
        send_pixel(pix(1600, 1600, 160, 100, 100, 3500, 1'b0));
        send_pixel(pix(1600, 1600, 160, 100, 101, 4000, 1'b1));
        // All fields at their maximum, then all at zero giving an empty store.
        send_pixel(pix(16383, 16383, 16383, 1023, 1023, 65535, 1'b1));
        send_pixel(pix(0, 0, 0, 0, 0, 0, 1'b1));
        // A centre on a half pixel rounds up; a zero radius still samples at two pixels.
        send_pixel(pix(8, 8, 0, 3, 1, 600, 1'b0));
        send_pixel(pix(8, 8, 0, 3, 2, 600, 1'b0));
        send_pixel(pix(8, 8, 0, 1, 1, 700, 1'b1));
        // Image edge, a pixel with its own centre, and a last pixel whose centre is outside.
        send_pixel(pix(10224, 3840, 160, 639, 240, 1000, 1'b0));
        send_pixel(pix(10224, 3840, 160, 640, 240, 1000, 1'b0));
        send_pixel(pix(3200, 3200, 32, 200, 200, 2000, 1'b0));
        send_pixel(pix(10224, 7680, 160, 639, 240, 1100, 1'b1));
        wait_results(DRAIN_CYCLES);

        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 36;
                recv_idle_pct = 74;
            end else if (ph < 5) begin
                send_idle_pct = 74;
                recv_idle_pct = 36;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            program_setting(ph);
            sent_in_phase = 0;
            paused = 1'b0;
            while (sent_in_phase < RANDOM_PIXELS / NUM_SETTINGS) begin
                dense = ($urandom_range(0, 24) == 0);
                len = dense ? $urandom_range(258, 300) : $urandom_range(1, 24);
                send_run(len, !dense && ($urandom_range(0, 4) == 0), dense);
                sent_in_phase += len;
                if (ph == 1 && !paused && sent_in_phase > RANDOM_PIXELS / NUM_SETTINGS / 2) begin
                    wait_results(0);
                    paused = 1'b1;
                end
            end
            wait_results(DRAIN_CYCLES);
        end

        $display("Sent %0d pixel requests across the reset values and %0d register settings.",
                 pixels_sent, NUM_SETTINGS);
        $display("Results seen: %0d ok, %0d centre outside, %0d too few, %0d with overflow.",
                 ok_results, outside_results, few_results, overflow_results);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
